// ----- sv/jsv_pkg.sv -----
package jsv_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int LVL_W = 9;
    localparam int IDX_W = 8;

    typedef enum logic [3:0] {
        M_TOP, M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_COMMA,
        M_DONE, M_VSTR, M_NUM, M_LIT, M_KSTR
    } mode_t;

    typedef enum logic [2:0] {
        N_SIGN, N_MANT, N_ZERO, N_DOT, N_FRAC, N_E, N_ESIGN, N_EXP
    } num_t;

    typedef enum logic [3:0] {
        S_OUT, S_NORM, S_ESC, S_HI1, S_HI2, S_HI3, S_HI4, S_EXPB, S_EXPU,
        S_LO1, S_LO2, S_LO3, S_LO4
    } str_t;

    typedef enum logic [2:0] {
        E_OK, E_LIT, E_STR, E_NUM, E_STRUCT, E_TRAIL, E_TRUNC, E_DEEP
    } err_t;

    localparam logic [3:0] C_WS = 4'd0;
    localparam logic [3:0] C_OBJ_OPEN = 4'd1;
    localparam logic [3:0] C_OBJ_CLOSE = 4'd2;
    localparam logic [3:0] C_ARR_OPEN = 4'd3;
    localparam logic [3:0] C_ARR_CLOSE = 4'd4;
    localparam logic [3:0] C_COLON = 4'd5;
    localparam logic [3:0] C_COMMA = 4'd6;
    localparam logic [3:0] C_KEY = 4'd7;
    localparam logic [3:0] C_VSTR = 4'd8;
    localparam logic [3:0] C_NUM = 4'd9;
    localparam logic [3:0] C_LIT = 4'd10;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [3:0] byte_class;
        logic [8:0] depth;
        logic       value_end;
        logic [1:0] number_kind;
        logic [2:0] error_code;
        logic       doc_ok;
    } out_item_t;

    // Literal letters: word 1 null, 2 true, 3 false
    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            2'd1: case (i)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
            2'd2: case (i)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd3: case (i)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/jsv_if.sv -----
interface jsv_in_if;
    import jsv_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface jsv_out_if;
    import jsv_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/json_syntax_validator_top.sv -----
// JSON syntax validator.
// Channels: in_ch carries one document byte per transaction (byte_req, last);
// out_ch returns exactly one result per byte (class, depth, value end,
// number kind, sticky error code, doc_ok on the last byte).
// cfg_we/cfg_wdata write max_depth; write only while the block is idle.
// The result is registered and presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless out_ch stalls. The per-byte parse
// step is a single pass of logic over the parser state; the container kinds
// sit in a 256 x 1 array written on each push. The top kind and the kind
// below it are held in registers, and the array is read once per byte,
// registered, to refill the entry below the top after a push or a pop.
// Reset: max_depth returns to 256, parser at top level, no error, empty
// output register. The parser state also returns to reset after every last byte.
// Stall: the output register holds while out_ch.ready is low; a new byte is
// still accepted when the held result is taken in the same cycle, so a
// stalled receiver stalls the sender with no bubble and no loss.
module json_syntax_validator_top
    import jsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    jsv_in_if.sink      in_ch,
    jsv_out_if.source   out_ch
);

    logic [8:0]       max_depth_reg;
    mode_t            mode_reg, mode_next;
    num_t             nph_reg, nph_next;
    logic             frac_reg, frac_next;
    str_t             sph_reg, sph_next;
    logic [15:0]      hex_reg, hex_next;
    logic [4:0]       utf_reg, utf_next;
    logic [4:0]       lit_reg, lit_next;
    err_t             err_reg, err_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             stack_mem [STACK_DEPTH];
    logic             top_reg;
    logic             below_reg;
    logic             top_kind;
    logic             push, push_kind;
    logic             out_valid_reg;
    out_item_t        out_reg, res;
    logic             take;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;
    assign top_kind = top_reg;

    // Hold the depth limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            max_depth_reg <= cfg_wdata;
        end
    end

    // Per-byte parse step
    always_comb
    begin
        logic [7:0] b;
        logic       last, ws, dig, is_e, ok, redispatch, vend, key;
        logic [3:0] cls;
        logic [1:0] kind;
        logic [8:0] limit;
        logic [2:0] li, lw;
        logic [3:0] hv;
        logic       hok;
        logic [15:0] hx;
        logic [7:0] lo, hi;
        b = in_ch.payload.byte_req;
        last = in_ch.payload.last;
        mode_next = mode_reg; nph_next = nph_reg; frac_next = frac_reg;
        sph_next = sph_reg; hex_next = hex_reg; utf_next = utf_reg;
        lit_next = lit_reg; err_next = err_reg; lvl_next = lvl_reg;
        push = 1'b0; push_kind = 1'b0; ok = 1'b0;
        cls = C_WS; vend = 1'b0; kind = 2'd0; redispatch = 1'b0;
        ws = (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
        dig = (b >= 8'h30) && (b <= 8'h39);
        is_e = (b == "e") || (b == "E");
        limit = (max_depth_reg > 9'(STACK_DEPTH)) ? 9'(STACK_DEPTH) : max_depth_reg;
        key = (mode_reg == M_KSTR);
        hok = 1'b1; hv = 4'd0;
        if (dig) hv = b[3:0];
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) hv = 4'(b[2:0] + 4'd9);
        else hok = 1'b0;
        hx = {hex_reg[11:0], hv};
        lw = {1'b0, lit_reg[4:3]}; li = lit_reg[2:0];
        lo = 8'h80; hi = 8'hBF;
        case (utf_reg[4:2])
            3'd1: lo = 8'hA0;
            3'd2: hi = 8'h9F;
            3'd3: lo = 8'h90;
            3'd4: hi = 8'h8F;
            default: ;
        endcase

        if (err_reg == E_OK)
        begin
            if (mode_reg == M_NUM)
            begin
                ok = 1'b0;
                case (nph_reg)
                    N_SIGN: if (dig) begin ok = 1'b1; nph_next = (b == "0") ? N_ZERO : N_MANT; end
                    N_MANT: begin
                        if (dig) ok = 1'b1;
                        else if (b == ".") begin ok = 1'b1; nph_next = N_DOT; end
                        else if (is_e) begin ok = 1'b1; nph_next = N_E; end
                    end
                    N_ZERO: begin
                        if (b == ".") begin ok = 1'b1; nph_next = N_DOT; end
                        else if (is_e) begin ok = 1'b1; nph_next = N_E; end
                    end
                    N_DOT: if (dig) begin ok = 1'b1; nph_next = N_FRAC; frac_next = 1'b1; end
                    N_FRAC: begin
                        if (dig) ok = 1'b1;
                        else if (is_e) begin ok = 1'b1; nph_next = N_E; end
                    end
                    N_E: begin
                        if (dig) begin ok = 1'b1; nph_next = N_EXP; end
                        else if (b == "+" || b == "-") begin ok = 1'b1; nph_next = N_ESIGN; end
                    end
                    N_ESIGN: if (dig) begin ok = 1'b1; nph_next = N_EXP; end
                    default: ok = dig;
                endcase
                if (ok) cls = C_NUM;
                else if (nph_reg == N_MANT || nph_reg == N_ZERO || nph_reg == N_FRAC ||
                         nph_reg == N_EXP)
                begin
                    vend = 1'b1;
                    kind = frac_reg ? 2'd3 : ((nph_reg == N_EXP) ? 2'd2 : 2'd1);
                    nph_next = N_SIGN; frac_next = 1'b0;
                    mode_next = (lvl_reg == '0) ? M_DONE : M_COMMA;
                    redispatch = 1'b1;
                end
                else err_next = E_NUM;
            end
            else redispatch = 1'b1;

            if (redispatch)
            begin
                case (mode_next)
                    M_VSTR, M_KSTR: begin
                        cls = key ? C_KEY : C_VSTR;
                        if (utf_reg != 5'd0)
                        begin
                            if (b < lo || b > hi) err_next = E_STR;
                            else utf_next = 5'({3'd0, utf_reg[1:0]} - 5'd1);
                        end
                        else
                        begin
                            case (sph_reg)
                                S_NORM: begin
                                    if (b < 8'h20) err_next = E_STR;
                                    else if (b == 8'h22)
                                    begin
                                        sph_next = S_OUT;
                                        if (key) mode_next = M_COLON;
                                        else
                                        begin
                                            vend = 1'b1;
                                            mode_next = (lvl_reg == '0) ? M_DONE : M_COMMA;
                                        end
                                    end
                                    else if (b == 8'h5C) sph_next = S_ESC;
                                    else if (b >= 8'h80)
                                    begin
                                        if (b >= 8'hC2 && b <= 8'hDF) utf_next = 5'd1;
                                        else if (b == 8'hE0) utf_next = 5'b00110;
                                        else if (b == 8'hED) utf_next = 5'b01010;
                                        else if (b >= 8'hE1 && b <= 8'hEF) utf_next = 5'd2;
                                        else if (b == 8'hF0) utf_next = 5'b01111;
                                        else if (b == 8'hF4) utf_next = 5'b10011;
                                        else if (b >= 8'hF1 && b <= 8'hF3) utf_next = 5'd3;
                                        else err_next = E_STR;
                                    end
                                end
                                S_ESC: begin
                                    if (b == "u") begin sph_next = S_HI1; hex_next = '0; end
                                    else if (b == 8'h22 || b == 8'h5C || b == "/" || b == "b" ||
                                             b == "f" || b == "n" || b == "r" || b == "t")
                                        sph_next = S_NORM;
                                    else err_next = E_STR;
                                end
                                S_HI1, S_HI2, S_HI3, S_HI4, S_LO1, S_LO2, S_LO3, S_LO4: begin
                                    if (!hok) err_next = E_STR;
                                    else
                                    begin
                                        hex_next = hx;
                                        if (sph_reg == S_HI4)
                                        begin
                                            if (hx[15:10] == 6'b110110) sph_next = S_EXPB;
                                            else if (hx[15:10] == 6'b110111) err_next = E_STR;
                                            else sph_next = S_NORM;
                                        end
                                        else if (sph_reg == S_LO4)
                                        begin
                                            if (hx[15:10] != 6'b110111) err_next = E_STR;
                                            else sph_next = S_NORM;
                                        end
                                        else sph_next = str_t'(sph_reg + 4'd1);
                                    end
                                end
                                S_EXPB: if (b != 8'h5C) err_next = E_STR; else sph_next = S_EXPU;
                                S_EXPU: begin
                                    if (b != "u") err_next = E_STR;
                                    else begin sph_next = S_LO1; hex_next = '0; end
                                end
                                default: err_next = E_STR;
                            endcase
                        end
                    end
                    M_LIT: begin
                        if (lw == 3'd0 || li >= ((lw == 3'd3) ? 3'd5 : 3'd4) ||
                            b != lit_char(lit_reg[4:3], li))
                            err_next = E_LIT;
                        else
                        begin
                            cls = C_LIT;
                            if (li + 3'd1 == ((lw == 3'd3) ? 3'd5 : 3'd4))
                            begin
                                lit_next = '0; vend = 1'b1;
                                mode_next = (lvl_reg == '0) ? M_DONE : M_COMMA;
                            end
                            else lit_next = {lit_reg[4:3], li + 3'd1};
                        end
                    end
                    default: begin
                        if (ws) cls = C_WS;
                        else
                        begin
                            case (mode_next)
                                M_TOP, M_VALUE, M_ARR_FIRST: begin
                                    if (mode_next == M_ARR_FIRST && b == "]")
                                    begin
                                        if (top_kind != 1'b1 || lvl_reg == '0) err_next = E_STRUCT;
                                        else
                                        begin
                                            lvl_next = lvl_reg - 1'b1; cls = C_ARR_CLOSE;
                                            mode_next = (lvl_next == '0) ? M_DONE : M_COMMA;
                                        end
                                    end
                                    else if (b == 8'h22)
                                    begin
                                        mode_next = M_VSTR; sph_next = S_NORM; cls = C_VSTR;
                                    end
                                    else if (b == "-" || dig)
                                    begin
                                        mode_next = M_NUM; frac_next = 1'b0; cls = C_NUM;
                                        nph_next = (b == "-") ? N_SIGN :
                                                   ((b == "0") ? N_ZERO : N_MANT);
                                    end
                                    else if (b == "n" || b == "t" || b == "f")
                                    begin
                                        mode_next = M_LIT; cls = C_LIT;
                                        lit_next = {(b == "n") ? 2'd1 : ((b == "t") ? 2'd2 : 2'd3),
                                                    3'd1};
                                    end
                                    else if (b == "{" || b == "[")
                                    begin
                                        if (lvl_reg >= limit) err_next = E_DEEP;
                                        else
                                        begin
                                            push = 1'b1; push_kind = (b == "[");
                                            lvl_next = lvl_reg + 1'b1;
                                            mode_next = (b == "[") ? M_ARR_FIRST : M_OBJ_FIRST;
                                            cls = (b == "[") ? C_ARR_OPEN : C_OBJ_OPEN;
                                        end
                                    end
                                    else err_next = E_STRUCT;
                                end
                                M_OBJ_FIRST, M_KEY: begin
                                    if (b == 8'h22)
                                    begin
                                        mode_next = M_KSTR; sph_next = S_NORM; cls = C_KEY;
                                    end
                                    else if (b == "}" && mode_next == M_OBJ_FIRST &&
                                             lvl_reg != '0 && top_kind == 1'b0)
                                    begin
                                        lvl_next = lvl_reg - 1'b1; cls = C_OBJ_CLOSE;
                                        mode_next = (lvl_next == '0) ? M_DONE : M_COMMA;
                                    end
                                    else err_next = E_STRUCT;
                                end
                                M_COLON: begin
                                    if (b == ":") begin mode_next = M_VALUE; cls = C_COLON; end
                                    else err_next = E_STRUCT;
                                end
                                M_COMMA: begin
                                    if (lvl_reg == '0) err_next = E_STRUCT;
                                    else if (b == ",")
                                    begin
                                        mode_next = top_kind ? M_VALUE : M_KEY; cls = C_COMMA;
                                    end
                                    else if ((b == "}" && top_kind == 1'b0) ||
                                             (b == "]" && top_kind == 1'b1))
                                    begin
                                        lvl_next = lvl_reg - 1'b1;
                                        cls = top_kind ? C_ARR_CLOSE : C_OBJ_CLOSE;
                                        mode_next = (lvl_next == '0) ? M_DONE : M_COMMA;
                                    end
                                    else err_next = E_STRUCT;
                                end
                                M_DONE: err_next = E_TRAIL;
                                default: err_next = E_STRUCT;
                            endcase
                        end
                    end
                endcase
            end

            // Close out the document on its last byte
            if (last && err_next == E_OK)
            begin
                if (mode_next == M_NUM)
                begin
                    if (nph_next == N_MANT || nph_next == N_ZERO || nph_next == N_FRAC ||
                        nph_next == N_EXP)
                    begin
                        vend = 1'b1;
                        kind = frac_next ? 2'd3 : ((nph_next == N_EXP) ? 2'd2 : 2'd1);
                        mode_next = (lvl_next == '0) ? M_DONE : M_COMMA;
                    end
                    else err_next = E_NUM;
                end
                if (err_next == E_OK)
                begin
                    if (mode_next == M_VSTR || mode_next == M_KSTR) err_next = E_STR;
                    else if (mode_next == M_LIT) err_next = E_LIT;
                    else if (mode_next != M_DONE) err_next = E_TRUNC;
                end
            end
        end

        if (err_next != E_OK) begin cls = C_WS; vend = 1'b0; kind = 2'd0; push = 1'b0; end

        res.byte_class = cls;
        res.depth = 9'(lvl_next);
        res.value_end = vend;
        res.number_kind = kind;
        res.error_code = err_next;
        res.doc_ok = last && (err_next == E_OK);
    end

    // Advance parser state on each accepted byte; clear after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_TOP; nph_reg <= N_SIGN; frac_reg <= 1'b0; sph_reg <= S_OUT;
            hex_reg <= '0; utf_reg <= '0; lit_reg <= '0; err_reg <= E_OK; lvl_reg <= '0;
        end
        else if (take)
        begin
            if (in_ch.payload.last)
            begin
                mode_reg <= M_TOP; nph_reg <= N_SIGN; frac_reg <= 1'b0; sph_reg <= S_OUT;
                hex_reg <= '0; utf_reg <= '0; lit_reg <= '0; err_reg <= E_OK; lvl_reg <= '0;
            end
            else
            begin
                mode_reg <= mode_next; nph_reg <= nph_next; frac_reg <= frac_next;
                sph_reg <= sph_next; hex_reg <= hex_next; utf_reg <= utf_next;
                lit_reg <= lit_next; err_reg <= err_next; lvl_reg <= lvl_next;
            end
        end
    end

    // Track the kind at the top of the stack
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= 1'b0;
        end
        else if (take)
        begin
            if (push) top_reg <= push_kind;
            else if (lvl_next < lvl_reg) top_reg <= below_reg;
        end
    end

    // Push the container kind; fetch the entry below the new top
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (push) stack_mem[IDX_W'(lvl_reg)] <= push_kind;
            below_reg <= stack_mem[IDX_W'(lvl_next - 9'd2)];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= res;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result changed under stall");
    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= 9'(STACK_DEPTH))
        else $error("stack level beyond depth");
    a_errcls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.error_code != E_OK |->
        out_reg.byte_class == C_WS && !out_reg.value_end)
        else $error("class reported with error");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_ch.payload.last |=> lvl_reg == '0 && err_reg == E_OK)
        else $error("state not cleared after last byte");

endmodule
